>>> hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPL(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("assertion failed");
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error("never failed");
`else
`define ASSERT_IMPL(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

>>> hw/rtl/rvdx_pkg.sv
// Types and constants for the RV32I decode/execute/predict block
package rvdx_pkg;
  localparam logic [6:0] OPC_LUI    = 7'b0110111;
  localparam logic [6:0] OPC_AUIPC  = 7'b0010111;
  localparam logic [6:0] OPC_JAL    = 7'b1101111;
  localparam logic [6:0] OPC_JALR   = 7'b1100111;
  localparam logic [6:0] OPC_BRANCH = 7'b1100011;
  localparam logic [6:0] OPC_LOAD   = 7'b0000011;
  localparam logic [6:0] OPC_STORE  = 7'b0100011;
  localparam logic [6:0] OPC_OPIMM  = 7'b0010011;
  localparam logic [6:0] OPC_OP     = 7'b0110011;
  localparam logic [6:0] F7_ALT     = 7'b0100000;

  typedef enum logic [2:0] {
    CLS_ALU = 3'd0, CLS_LOAD = 3'd1, CLS_STORE = 3'd2,
    CLS_BRANCH = 3'd3, CLS_JUMP = 3'd4, CLS_ILL = 3'd5
  } op_class_t;

  typedef enum logic [2:0] {
    AOP_ADD = 3'd0, AOP_SLL = 3'd1, AOP_SLT = 3'd2, AOP_SLTU = 3'd3,
    AOP_XOR = 3'd4, AOP_SR = 3'd5, AOP_OR = 3'd6, AOP_AND = 3'd7
  } alu_op_t;

  localparam logic [2:0] BR_EQ = 3'd0, BR_NE = 3'd1, BR_LT = 3'd4,
                         BR_GE = 3'd5, BR_LTU = 3'd6, BR_GEU = 3'd7;

  // Decoded request handed from front to back
  typedef struct packed {
    op_class_t   cls;
    logic [4:0]  rd;
    alu_op_t     aop;
    logic        alt;
    logic        use_imm;
    logic        is_lui;
    logic        is_auipc;
    logic        is_jalr;
    logic [2:0]  f3;
    logic [2:0]  kind;
    logic [31:0] imm;
    logic [31:0] pc;
    logic [31:0] a;
    logic [31:0] b;
  } dec_t;
endpackage

>>> hw/rtl/rvdx_front.sv
// Front end: accepts and decodes instructions
module rvdx_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [31:0]      in_instruction,
  input  logic [31:0]      in_pc,
  input  logic [31:0]      in_rs1_value,
  input  logic [31:0]      in_rs2_value,
  output logic             dec_valid,
  input  logic             dec_stall,
  output rvdx_pkg::dec_t   dec_data
);
  import rvdx_pkg::*;

  logic        vld_r;
  dec_t        dat_r;
  dec_t        d;
  logic [31:0] ins;
  logic [6:0]  opc, f7;
  logic [2:0]  f3;

  assign ins = in_instruction;
  assign opc = ins[6:0];
  assign f3  = ins[14:12];
  assign f7  = ins[31:25];

  always_comb begin
    d          = '0;
    d.cls      = CLS_ILL;
    d.pc       = in_pc;
    d.a        = in_rs1_value;
    d.b        = in_rs2_value;
    d.f3       = f3;
    d.aop      = alu_op_t'(f3);
    d.rd       = ins[11:7];
    d.imm      = {{20{ins[31]}}, ins[31:20]};
    unique case (opc)
      OPC_LUI: begin
        d.cls = CLS_ALU; d.is_lui = 1'b1; d.imm = {ins[31:12], 12'd0};
      end
      OPC_AUIPC: begin
        d.cls = CLS_ALU; d.is_auipc = 1'b1; d.imm = {ins[31:12], 12'd0};
      end
      OPC_JAL: begin
        d.cls = CLS_JUMP;
        d.imm = {{12{ins[31]}}, ins[19:12], ins[20], ins[30:21], 1'b0};
      end
      OPC_JALR: if (f3 == 3'd0) begin
        d.cls = CLS_JUMP; d.is_jalr = 1'b1;
      end
      OPC_BRANCH: begin
        d.imm = {{20{ins[31]}}, ins[7], ins[30:25], ins[11:8], 1'b0};
        case (f3)
          BR_EQ:  begin d.cls = CLS_BRANCH; d.kind = 3'd0; end
          BR_NE:  begin d.cls = CLS_BRANCH; d.kind = 3'd1; end
          BR_LT:  begin d.cls = CLS_BRANCH; d.kind = 3'd2; end
          BR_GE:  begin d.cls = CLS_BRANCH; d.kind = 3'd3; end
          BR_LTU: begin d.cls = CLS_BRANCH; d.kind = 3'd4; end
          BR_GEU: begin d.cls = CLS_BRANCH; d.kind = 3'd5; end
          default: d.cls = CLS_ILL;
        endcase
      end
      OPC_LOAD: if (!(f3 == 3'd3 || f3 == 3'd6 || f3 == 3'd7)) d.cls = CLS_LOAD;
      OPC_STORE: begin
        d.imm = {{20{ins[31]}}, ins[31:25], ins[11:7]};
        if (f3 <= 3'd2) d.cls = CLS_STORE;
      end
      OPC_OPIMM: begin
        d.use_imm = 1'b1;
        d.alt = (f3 == 3'd5) && (f7 == F7_ALT);
        if (f3 == 3'd1) begin
          if (f7 == 7'd0) d.cls = CLS_ALU;
        end else if (f3 == 3'd5) begin
          if (f7 == 7'd0 || f7 == F7_ALT) d.cls = CLS_ALU;
        end else begin
          d.cls = CLS_ALU;
        end
      end
      OPC_OP: begin
        d.alt = (f7 == F7_ALT);
        if (f3 == 3'd0 || f3 == 3'd5) begin
          if (f7 == 7'd0 || f7 == F7_ALT) d.cls = CLS_ALU;
        end else if (f7 == 7'd0) begin
          d.cls = CLS_ALU;
        end
      end
      default: d.cls = CLS_ILL;
    endcase
    if (d.cls == CLS_STORE || d.cls == CLS_BRANCH || d.cls == CLS_ILL) d.rd = 5'd0;
  end

  assign in_stall  = vld_r && dec_stall;
  assign dec_valid = vld_r;
  assign dec_data  = dat_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (!in_stall) begin
      vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      dat_r <= d;
    end
  end
endmodule

>>> hw/rtl/rvdx_queue.sv
// Two-entry request queue between front and back
module rvdx_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           wr_valid,
  output logic           wr_stall,
  input  rvdx_pkg::dec_t wr_data,
  output logic           rd_valid,
  input  logic           rd_stall,
  output rvdx_pkg::dec_t rd_data
);
  import rvdx_pkg::*;

  dec_t       mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       wr_en, rd_en;

  assign wr_stall = (cnt_r == 2'd2);
  assign rd_valid = (cnt_r != 2'd0);
  assign rd_data  = mem_r[rp_r];
  assign wr_en    = wr_valid && !wr_stall;
  assign rd_en    = rd_valid && !rd_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (wr_en) wp_r <= ~wp_r;
      if (rd_en) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, wr_en} - {1'b0, rd_en};
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wp_r] <= wr_data;
    end
  end
endmodule

>>> hw/rtl/rvdx_back.sv
// Back end: executes requests, predicts and trains branches
module rvdx_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           req_valid,
  output logic           req_stall,
  input  rvdx_pkg::dec_t req,
  output logic           out_valid,
  input  logic           out_stall,
  output logic [2:0]     out_op_class,
  output logic [4:0]     out_dest_reg,
  output logic [31:0]    out_write_value,
  output logic [31:0]    out_mem_address,
  output logic [31:0]    out_store_data,
  output logic [1:0]     out_access_width,
  output logic           out_load_unsigned,
  output logic           out_predicted_taken,
  output logic           out_actual_taken,
  output logic [31:0]    out_next_pc
);
  import rvdx_pkg::*;

  logic [1:0]  ctr_r [6];
  logic        vld_r;
  logic [2:0]  cls_r;
  logic [4:0]  rd_r;
  logic [31:0] wv_r, addr_r, sd_r, npc_r;
  logic [1:0]  aw_r;
  logic        lu_r, pt_r, at_r;

  logic [31:0] a, b, opb, alu_res, sum, pc4, wv, addr, sd, npc;
  logic [1:0]  aw, ctr;
  logic        lu, pt, at, cond, slt, sltu, take;

  assign take      = req_valid && !req_stall;
  assign req_stall = vld_r && out_stall;
  assign a    = req.a;
  assign b    = req.b;
  assign opb  = req.use_imm ? req.imm : b;
  assign slt  = $signed(a) < $signed(opb);
  assign sltu = a < opb;
  assign sum  = a + req.imm;
  assign pc4  = req.pc + 32'd4;
  assign ctr  = ctr_r[req.kind];

  always_comb begin
    case (req.aop)
      AOP_ADD:  alu_res = req.alt ? a - opb : a + opb;
      AOP_SLL:  alu_res = a << opb[4:0];
      AOP_SLT:  alu_res = {31'd0, slt};
      AOP_SLTU: alu_res = {31'd0, sltu};
      AOP_XOR:  alu_res = a ^ opb;
      AOP_SR:   alu_res = req.alt ? 32'($signed(a) >>> opb[4:0]) : a >> opb[4:0];
      AOP_OR:   alu_res = a | opb;
      default:  alu_res = a & opb;
    endcase
    case (req.f3)
      BR_EQ:   cond = a == b;
      BR_NE:   cond = a != b;
      BR_LT:   cond = $signed(a) < $signed(b);
      BR_GE:   cond = !($signed(a) < $signed(b));
      BR_LTU:  cond = a < b;
      default: cond = a >= b;
    endcase
  end

  always_comb begin
    wv = '0; addr = '0; sd = '0; aw = '0; lu = 1'b0; pt = 1'b0; at = 1'b0; npc = pc4;
    case (req.cls)
      CLS_ALU: begin
        if (req.is_lui) wv = req.imm;
        else if (req.is_auipc) wv = req.pc + req.imm;
        else wv = alu_res;
      end
      CLS_LOAD: begin
        addr = sum; aw = req.f3[1:0]; lu = req.f3[2];
      end
      CLS_STORE: begin
        addr = sum; aw = req.f3[1:0];
        sd = (req.f3 == 3'd0) ? {24'd0, b[7:0]} :
             (req.f3 == 3'd1) ? {16'd0, b[15:0]} : b;
      end
      CLS_BRANCH: begin
        pt = ctr[1]; at = cond;
        if (cond) npc = req.pc + req.imm;
      end
      CLS_JUMP: begin
        wv = pc4; at = 1'b1;
        npc = req.is_jalr ? {sum[31:1], 1'b0} : req.pc + req.imm;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
      for (int i = 0; i < 6; i++) ctr_r[i] <= 2'd3;
    end else begin
      if (!req_stall) vld_r <= req_valid;
      if (take && req.cls == CLS_BRANCH) begin
        if (cond && ctr != 2'd3) ctr_r[req.kind] <= ctr + 2'd1;
        else if (!cond && ctr != 2'd0) ctr_r[req.kind] <= ctr - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      cls_r <= req.cls; rd_r <= req.rd; wv_r <= wv; addr_r <= addr; sd_r <= sd;
      aw_r <= aw; lu_r <= lu; pt_r <= pt; at_r <= at; npc_r <= npc;
    end
  end

  assign out_valid           = vld_r;
  assign out_op_class        = cls_r;
  assign out_dest_reg        = rd_r;
  assign out_write_value     = wv_r;
  assign out_mem_address     = addr_r;
  assign out_store_data      = sd_r;
  assign out_access_width    = aw_r;
  assign out_load_unsigned   = lu_r;
  assign out_predicted_taken = pt_r;
  assign out_actual_taken    = at_r;
  assign out_next_pc         = npc_r;
endmodule

>>> hw/rtl/rv32i_decode_execute_predict.sv
// Top level of the RV32I decode/execute/predict block
//  channel | ports                     | direction
//  input   | in_valid/in_stall + fields| request in
//  result  | out_valid/out_stall+fields| request out
// One request per cycle sustained while out_stall stays low; a request passes through the
// front reg, a queue entry and the result reg, in that order.
// Synchronous active-low reset clears valids and sets all branch counters to 3.
// A stalled output fills the two-entry queue before in_stall rises.
`include "assert_macros.svh"
module rv32i_decode_execute_predict (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_instruction,
  input  logic [31:0] in_pc,
  input  logic [31:0] in_rs1_value,
  input  logic [31:0] in_rs2_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_op_class,
  output logic [4:0]  out_dest_reg,
  output logic [31:0] out_write_value,
  output logic [31:0] out_mem_address,
  output logic [31:0] out_store_data,
  output logic [1:0]  out_access_width,
  output logic        out_load_unsigned,
  output logic        out_predicted_taken,
  output logic        out_actual_taken,
  output logic [31:0] out_next_pc
);
  import rvdx_pkg::*;

  logic dv, ds, qv, qs;
  dec_t dd, qd;
  logic ill_loud;

  rvdx_front u_front (
    .clk, .rst_n, .in_valid, .in_stall, .in_instruction, .in_pc,
    .in_rs1_value, .in_rs2_value, .dec_valid(dv), .dec_stall(ds), .dec_data(dd)
  );

  rvdx_queue u_queue (
    .clk, .rst_n, .wr_valid(dv), .wr_stall(ds), .wr_data(dd),
    .rd_valid(qv), .rd_stall(qs), .rd_data(qd)
  );

  rvdx_back u_back (
    .clk, .rst_n, .req_valid(qv), .req_stall(qs), .req(qd), .out_valid, .out_stall,
    .out_op_class, .out_dest_reg, .out_write_value, .out_mem_address, .out_store_data,
    .out_access_width, .out_load_unsigned, .out_predicted_taken, .out_actual_taken,
    .out_next_pc
  );

  // illegal result that still reports a destination or a taken flag
  assign ill_loud = (out_op_class == CLS_ILL) && (out_dest_reg != 5'd0 || out_actual_taken);

  `ASSERT_NEVER(a_cls_range, clk, rst_n, out_valid && out_op_class > 3'd5)
  `ASSERT_NEVER(a_ill_quiet, clk, rst_n, out_valid && ill_loud)
  `ASSERT_IMPL(a_jump_taken, clk, rst_n, (out_valid && out_op_class == CLS_JUMP) |-> out_actual_taken)
endmodule

>>> sim/tb_rv32i_decode_execute_predict.sv
// Testbench for the RV32I decode/execute/predict block: directed and random requests
module tb_rv32i_decode_execute_predict;
  import rvdx_pkg::*;

  typedef struct {
    op_class_t   cls;
    logic [4:0]  rd;
    logic [31:0] wv;
    logic [31:0] addr;
    logic [31:0] sd;
    logic [1:0]  aw;
    logic        lu;
    logic        pt;
    logic        at;
    logic [31:0] npc;
  } exec_res_t;

  class exec_scoreboard;
    logic [1:0] ctr[6];
    exec_res_t  pending[$];
    int         errors;
    int         n_checked;
    int         n_branch;
    int         n_ill;

    function new();
      foreach (ctr[i]) ctr[i] = 2'd3;
      errors = 0;
      n_checked = 0;
      n_branch = 0;
      n_ill = 0;
    endfunction

    function logic [31:0] alu(logic [2:0] f3, logic alt, logic [31:0] a, logic [31:0] b);
      case (f3)
        AOP_ADD:  return alt ? a - b : a + b;
        AOP_SLL:  return a << b[4:0];
        AOP_SLT:  return {31'd0, $signed(a) < $signed(b)};
        AOP_SLTU: return {31'd0, a < b};
        AOP_XOR:  return a ^ b;
        AOP_SR:   return alt ? 32'($signed(a) >>> b[4:0]) : a >> b[4:0];
        AOP_OR:   return a | b;
        default:  return a & b;
      endcase
    endfunction

    function void note_request(logic [31:0] ins, logic [31:0] pc, logic [31:0] a,
                               logic [31:0] b);
      exec_res_t   r;
      logic [6:0]  opc, f7;
      logic [2:0]  f3;
      logic [31:0] immi, imms, immb, immj, immu;
      int          kind;
      logic        cond;
      opc = ins[6:0];
      f3 = ins[14:12];
      f7 = ins[31:25];
      immi = {{20{ins[31]}}, ins[31:20]};
      imms = {{20{ins[31]}}, ins[31:25], ins[11:7]};
      immb = {{19{ins[31]}}, ins[31], ins[7], ins[30:25], ins[11:8], 1'b0};
      immj = {{11{ins[31]}}, ins[31], ins[19:12], ins[20], ins[30:21], 1'b0};
      immu = {ins[31:12], 12'd0};
      r = '{cls: CLS_ILL, rd: 0, wv: 0, addr: 0, sd: 0, aw: 0, lu: 0, pt: 0, at: 0,
            npc: pc + 4};
      case (opc)
        OPC_LUI: begin
          r.cls = CLS_ALU; r.rd = ins[11:7]; r.wv = immu;
        end
        OPC_AUIPC: begin
          r.cls = CLS_ALU; r.rd = ins[11:7]; r.wv = pc + immu;
        end
        OPC_JAL: begin
          r.cls = CLS_JUMP; r.rd = ins[11:7]; r.wv = pc + 4; r.at = 1; r.npc = pc + immj;
        end
        OPC_JALR: if (f3 == 0) begin
          r.cls = CLS_JUMP; r.rd = ins[11:7]; r.wv = pc + 4; r.at = 1;
          r.npc = (a + immi) & ~32'd1;
        end
        OPC_BRANCH: begin
          kind = -1;
          cond = 0;
          case (f3)
            BR_EQ:  begin kind = 0; cond = a == b; end
            BR_NE:  begin kind = 1; cond = a != b; end
            BR_LT:  begin kind = 2; cond = $signed(a) < $signed(b); end
            BR_GE:  begin kind = 3; cond = !($signed(a) < $signed(b)); end
            BR_LTU: begin kind = 4; cond = a < b; end
            BR_GEU: begin kind = 5; cond = a >= b; end
            default: ;
          endcase
          if (kind >= 0) begin
            n_branch++;
            r.cls = CLS_BRANCH;
            r.pt = ctr[kind][1];
            r.at = cond;
            if (cond) begin
              r.npc = pc + immb;
              if (ctr[kind] != 3) ctr[kind]++;
            end else if (ctr[kind] != 0) begin
              ctr[kind]--;
            end
          end
        end
        OPC_LOAD: if (!(f3 == 3 || f3 > 5)) begin
          r.cls = CLS_LOAD; r.rd = ins[11:7]; r.addr = a + immi;
          r.aw = f3[1:0]; r.lu = f3[2];
        end
        OPC_STORE: if (f3 <= 2) begin
          r.cls = CLS_STORE; r.addr = a + imms; r.aw = f3[1:0];
          r.sd = f3 == 0 ? (b & 32'hFF) : f3 == 1 ? (b & 32'hFFFF) : b;
        end
        OPC_OPIMM: if (!((f3 == AOP_SLL && f7 != 0) ||
                         (f3 == AOP_SR && f7 != 0 && f7 != F7_ALT))) begin
          r.cls = CLS_ALU; r.rd = ins[11:7];
          r.wv = alu(f3, f3 == AOP_SR && f7 == F7_ALT, a, immi);
        end
        OPC_OP: if ((f3 == AOP_ADD || f3 == AOP_SR) ? (f7 == 0 || f7 == F7_ALT) : f7 == 0)
        begin
          r.cls = CLS_ALU; r.rd = ins[11:7];
          r.wv = alu(f3, f7 == F7_ALT, a, b);
        end
        default: ;
      endcase
      if (r.cls == CLS_ILL) n_ill++;
      pending.push_back(r);
    endfunction

    function void check_result(exec_res_t got);
      exec_res_t e;
      if (pending.size() == 0) begin
        $error("result with no request pending");
        errors++;
        return;
      end
      e = pending.pop_front();
      n_checked++;
      if (got.cls !== e.cls) begin
        $error("op_class exp %0d got %0d", e.cls, got.cls); errors++;
      end
      if (got.rd !== e.rd) begin
        $error("dest_reg exp %0d got %0d", e.rd, got.rd); errors++;
      end
      if (got.wv !== e.wv) begin
        $error("write_value exp %h got %h", e.wv, got.wv); errors++;
      end
      if (got.addr !== e.addr) begin
        $error("mem_address exp %h got %h", e.addr, got.addr); errors++;
      end
      if (got.sd !== e.sd) begin
        $error("store_data exp %h got %h", e.sd, got.sd); errors++;
      end
      if (got.aw !== e.aw) begin
        $error("access_width exp %0d got %0d", e.aw, got.aw); errors++;
      end
      if (got.lu !== e.lu) begin
        $error("load_unsigned exp %0d got %0d", e.lu, got.lu); errors++;
      end
      if (got.pt !== e.pt) begin
        $error("predicted_taken exp %0d got %0d", e.pt, got.pt); errors++;
      end
      if (got.at !== e.at) begin
        $error("actual_taken exp %0d got %0d", e.at, got.at); errors++;
      end
      if (got.npc !== e.npc) begin
        $error("next_pc exp %h got %h", e.npc, got.npc); errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [31:0] in_instruction;
  logic [31:0] in_pc;
  logic [31:0] in_rs1_value;
  logic [31:0] in_rs2_value;
  logic        out_valid;
  logic        out_stall;
  logic [2:0]  out_op_class;
  logic [4:0]  out_dest_reg;
  logic [31:0] out_write_value;
  logic [31:0] out_mem_address;
  logic [31:0] out_store_data;
  logic [1:0]  out_access_width;
  logic        out_load_unsigned;
  logic        out_predicted_taken;
  logic        out_actual_taken;
  logic [31:0] out_next_pc;

  exec_scoreboard sb;
  bit             stim_done;

  rv32i_decode_execute_predict i_dut (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20000000;
    $display("FAIL");
    $finish;
  end

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 50) return 0;
    if (p < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 20);
  endfunction

  // one request, held until accepted; valid stays high into a zero gap
  task automatic send(logic [31:0] ins, logic [31:0] pc, logic [31:0] a, logic [31:0] b,
                      int gap);
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1;
    in_instruction <= ins;
    in_pc <= pc;
    in_rs1_value <= a;
    in_rs2_value <= b;
    do @(posedge clk); while (in_stall);
    sb.note_request(ins, pc, a, b);
  endtask

  function automatic logic [31:0] rand_val();
    case ($urandom_range(0, 5))
      0: return 0;
      1: return 32'hFFFF_FFFF;
      2: return 32'h8000_0000;
      3: return $urandom_range(0, 7);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] rand_ins();
    logic [31:0] ins;
    logic [6:0]  opcs[9];
    opcs = '{OPC_LUI, OPC_AUIPC, OPC_JAL, OPC_JALR, OPC_BRANCH, OPC_LOAD, OPC_STORE,
             OPC_OPIMM, OPC_OP};
    ins = $urandom;
    if ($urandom_range(0, 9) == 0) return ins;
    ins[6:0] = opcs[$urandom_range(0, 8)];
    if ($urandom_range(0, 3) != 0) begin
      case (ins[6:0])
        OPC_JALR:   ins[14:12] = 3'd0;
        OPC_LOAD:   ins[14:12] = 3'($urandom_range(0, 5));
        OPC_STORE:  ins[14:12] = 3'($urandom_range(0, 2));
        OPC_OPIMM, OPC_OP:
          if (ins[14:12] inside {3'd0, 3'd1, 3'd5} || ins[6:0] == OPC_OP)
            ins[31:25] = $urandom_range(0, 1) ? F7_ALT : 7'd0;
        default: ;
      endcase
    end
    return ins;
  endfunction

  initial begin
    logic [31:0] a;
    sb = new();
    rst_n = 0;
    in_valid = 0;
    in_instruction = 0;
    in_pc = 0;
    in_rs1_value = 0;
    in_rs2_value = 0;
    stim_done = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    // directed: formats, extremes, illegal encodings, counter saturation
    send({20'hFFFFF, 5'd31, OPC_LUI}, 0, 0, 0, 0);
    send({20'h80000, 5'd0, OPC_AUIPC}, 32'hFFFF_FFFC, 0, 0, 0);
    send({1'b1, 10'h3FF, 1'b1, 8'hFF, 5'd1, OPC_JAL}, 32'h100, 0, 0, 0);
    send({12'h001, 5'd2, 3'd0, 5'd3, OPC_JALR}, 0, 32'hFFFF_FFFF, 0, 0);
    send({12'h000, 5'd2, 3'd1, 5'd3, OPC_JALR}, 0, 1, 0, 0);
    for (int f = 0; f < 8; f++)
      send({12'h800, 5'd1, 3'(f), 5'd4, OPC_LOAD}, 0, 32'h7FFF_FFFF, 0, 0);
    for (int f = 0; f < 4; f++)
      send({7'h7F, 5'd2, 5'd1, 3'(f), 5'h1F, OPC_STORE}, 0, 0, 32'hFFFF_FFFF, 0);
    send({7'h20, 5'd31, 5'd1, AOP_SR, 5'd5, OPC_OPIMM}, 0, 32'h8000_0000, 0, 0);
    send({7'h01, 5'd1, 5'd1, AOP_SLL, 5'd5, OPC_OPIMM}, 0, 1, 0, 0);
    send({7'h20, 5'd2, 5'd1, AOP_ADD, 5'd5, OPC_OP}, 0, 0, 1, 0);
    send({7'h20, 5'd2, 5'd1, AOP_XOR, 5'd5, OPC_OP}, 0, 0, 1, 0);
    send(32'hFFFF_FFFF, 32'hFFFF_FFFC, 0, 0, 0);
    for (int k = 0; k < 4; k++)
      send({1'b1, 6'h3F, 5'd2, 5'd1, BR_EQ, 4'hF, 1'b1, OPC_BRANCH}, 0, 1, 2, 0);
    send({1'b0, 6'h0, 5'd2, 5'd1, 3'd2, 4'h2, 1'b0, OPC_BRANCH}, 0, 1, 1, 0);
    // random
    for (int n = 0; n < 550; n++) begin
      a = rand_val();
      send(rand_ins(), $urandom, a, $urandom_range(0, 2) == 0 ? a : rand_val(),
           (n / 100) % 2 == 1 ? 0 : gap_len());
    end
    in_valid <= 0;
    stim_done = 1;
  end

  initial begin
    exec_res_t r;
    out_stall = 1;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if ($urandom_range(0, 30) == 0) begin
        out_stall <= 1;
        repeat ($urandom_range(4, 20)) @(posedge clk);
      end
      out_stall <= ($urandom_range(0, 2) == 0 && ($time / 5000) % 2 == 0);
      @(posedge clk);
      if (out_valid && !out_stall) begin
        r.cls = op_class_t'(out_op_class);
        r.rd = out_dest_reg;
        r.wv = out_write_value;
        r.addr = out_mem_address;
        r.sd = out_store_data;
        r.aw = out_access_width;
        r.lu = out_load_unsigned;
        r.pt = out_predicted_taken;
        r.at = out_actual_taken;
        r.npc = out_next_pc;
        sb.check_result(r);
      end
      if (stim_done && sb.pending.size() == 0) begin
        out_stall <= 0;
        repeat (10) begin
          @(posedge clk);
          if (out_valid) begin
            $error("unexpected result after drain");
            sb.errors++;
          end
        end
        $display("Checked %0d results: %0d branches, %0d illegal encodings.",
                 sb.n_checked, sb.n_branch, sb.n_ill);
        if (sb.errors == 0) $display("PASS");
        else $display("FAIL");
        $finish;
      end
    end
  end
endmodule
